[hdl/smd_pkg.sv]
// shared constants, register indexes and helper functions of the modulated delay
package smd_pkg;

  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int SINE_DEPTH_DEF  = 256;

  localparam int SAMPLE_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_COEFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_INC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 3'd6;

  // register reset values
  localparam logic [15:0] BASE_DELAY_RST = 16'd14400;
  localparam logic [11:0] MOD_DEPTH_RST  = 12'd288;
  localparam logic [15:0] FEEDBACK_RST   = 16'd26214;
  localparam logic [16:0] WET_MIX_RST    = 17'd32768;
  localparam logic [15:0] LP_COEFF_RST   = 16'd45548;
  localparam logic [23:0] LFO_INC_RST    = 24'd44739;

  localparam logic [16:0] MIX_ONE = 17'd65536;

  // serial multiplier: signed a times unsigned b
  localparam int MUL_AW = 26;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint S24_MAX = 64'sd8388607;
  localparam longint S24_MIN = -64'sd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'(S24_MAX)) r = 24'sh7fffff;
    else if (v < 48'(S24_MIN)) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // quarter-wave sine entry in q1.23 from an angle in q2.30, taylor series to x^15
  function automatic logic [23:0] sine_q23(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    logic neg;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    neg = 1'b1;
    for (int n = 1; n < 15; n += 2) begin
      term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
      if (neg) sum = sum - signed'(term);
      else sum = sum + signed'(term);
      neg = !neg;
    end
    if (sum < 0) sum = 0;
    r = (sum + 64) >>> 7;
    if (r > S24_MAX) r = S24_MAX;
    return r[23:0];
  endfunction

endpackage

[hdl/stereo_modulated_delay_core.sv]
// top level of the stereo modulated delay with damped feedback
// One stereo frame (two q1.23 samples) is taken per request, and one output frame is returned
// per request. All products go through a single bit-serial multiplier that retires one
// multiplier bit per cycle; a frame needs eleven products (lfo swing, then interpolation,
// lowpass, feedback and two mix terms per channel) plus the address and line-read states
// (ADDR, RDA, RDB, RDW) per channel and one lfo lookup, and the next frame can be taken in the
// cycle after the result moves to the output register; a stalled output register holds the
// core for as long as the stall lasts. With bypass set the frame goes from the idle state
// straight to the output state. One frame is worked on at a time; the next is taken as soon as
// the previous one sits in the output register. After reset the two delay lines are cleared to
// zero by a pass over all DELAY_DEPTH addresses, during which in_stall stays high;
// configuration writes are taken at any time (cfg_ready is always high) and must only be issued
// while no frame is in flight.
module stereo_modulated_delay_core #(
  parameter int DELAY_DEPTH = smd_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_DEPTH  = smd_pkg::SINE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [smd_pkg::SAMPLE_W-1:0]  in_left,
  input  logic signed [smd_pkg::SAMPLE_W-1:0]  in_right,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [smd_pkg::SAMPLE_W-1:0]  out_left,
  output logic signed [smd_pkg::SAMPLE_W-1:0]  out_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [smd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import smd_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int SIW = $clog2(SINE_DEPTH + 1);
  // delay in q.16 samples, wide enough for base plus swing and for the upper clamp
  localparam int DW  = (AW + 17 > 34) ? AW + 17 : 34;
  localparam int OW  = MUL_PW - 7;
  localparam logic signed [DW-1:0] DLY_LO = DW'(65536);
  localparam logic signed [DW-1:0] DLY_HI = DW'(longint'(DELAY_DEPTH - 2) * 65536);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_LFO    = 14'b00000000000100,
    S_OFS    = 14'b00000000001000,
    S_ADDR   = 14'b00000000010000,
    S_RDA    = 14'b00000000100000,
    S_RDB    = 14'b00000001000000,
    S_RDW    = 14'b00000010000000,
    S_INTERP = 14'b00000100000000,
    S_LP     = 14'b00001000000000,
    S_FB     = 14'b00010000000000,
    S_MIX1   = 14'b00100000000000,
    S_MIX2   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] base_r;
  logic [11:0] md_r;
  logic [15:0] fb_r;
  logic [16:0] mix_r;
  logic [15:0] coeff_r;
  logic [23:0] inc_r;
  logic        byp_r;

  // frame state
  logic [AW-1:0]          wp_r;
  logic [31:0]            phase_r;
  logic signed [23:0]     lpf_l_r, lpf_rt_r;
  logic [AW-1:0]          clr_addr_r;

  // per-frame working registers
  logic                   ch_r;       // 0 left, 1 right
  logic signed [23:0]     x_l_r, x_rt_r;
  logic signed [23:0]     y_l_r, y_rt_r;
  logic signed [24:0]     sine_r;
  logic signed [OW-1:0]   off_r;
  logic [AW-1:0]          n_r;
  logic [15:0]            f_r;
  logic signed [23:0]     a_r, b_r, rd_r;
  logic signed [MUL_PW-1:0] acc_r;
  logic                   mul_pend_r;
  logic                   out_valid_r;
  logic signed [23:0]     out_l_r, out_rt_r;

  // sine quarter table, built at elaboration
  logic [23:0] sine_rom [0:SINE_DEPTH];
  for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
    assign sine_rom[k] = sine_q23(XK);
  end

  // lfo table index: mirror the phase in odd quadrants
  logic [30:0]    lfo_u;
  logic [43:0]    lfo_prod;
  logic [SIW-1:0] lfo_idx;
  logic signed [24:0] lfo_mag;
  assign lfo_u    = phase_r[30] ? (31'h40000000 - {1'b0, phase_r[29:0]})
                                : {1'b0, phase_r[29:0]};
  assign lfo_prod = 44'(lfo_u) * 44'(SINE_DEPTH);
  assign lfo_idx  = lfo_prod[30+SIW-1:30];
  assign lfo_mag  = signed'({1'b0, sine_rom[lfo_idx]});

  // current channel operands
  logic signed [23:0] x_cur, lp_cur;
  assign x_cur  = ch_r ? x_rt_r : x_l_r;
  assign lp_cur = ch_r ? lpf_rt_r : lpf_l_r;

  logic [16:0] mix_eff;
  assign mix_eff = mix_r[16] ? MIX_ONE : mix_r;

  // delay for this channel, clamped into the line
  logic signed [DW-1:0] base_q, off_q, dly, dly_c;
  always_comb begin
    base_q = '0;
    base_q[31:16] = base_r;
    off_q = DW'(off_r);
    dly   = ch_r ? (base_q - off_q) : (base_q + off_q);
    if (dly < DLY_LO) dly_c = DLY_LO;
    else if (dly > DLY_HI) dly_c = DLY_HI;
    else dly_c = dly;
  end

  // tap addresses behind the write position
  logic [AW:0]   tap_diff;
  logic [AW-1:0] addr_a, addr_b, raddr;
  assign tap_diff = {1'b0, wp_r} - {1'b0, n_r};
  assign addr_a   = tap_diff[AW] ? AW'(tap_diff + (AW+1)'(DELAY_DEPTH)) : tap_diff[AW-1:0];
  assign addr_b   = (addr_a == '0) ? AW'(DELAY_DEPTH - 1) : addr_a - 1'b1;
  assign raddr    = (state_r == S_RDB) ? addr_b : addr_a;

  // delay lines
  logic               clearing;
  logic               we_l, we_rt;
  logic [AW-1:0]      waddr;
  logic signed [23:0] wdata, rdata_l, rdata_rt, rdata_c;
  logic               mul_done;
  logic signed [MUL_PW-1:0] mul_p;
  logic signed [MUL_PW-17:0] prod_sh;   // product floored by 2^16
  logic signed [23:0] fb_val;

  assign prod_sh  = mul_p[MUL_PW-1:16];
  assign fb_val   = sat24(48'(x_cur) + 48'(prod_sh));
  assign clearing = (state_r == S_CLEAR);
  assign waddr    = clearing ? clr_addr_r : wp_r;
  assign wdata    = clearing ? 24'sd0 : fb_val;
  assign we_l     = clearing || ((state_r == S_FB) && mul_done && !ch_r);
  assign we_rt    = clearing || ((state_r == S_FB) && mul_done && ch_r);
  assign rdata_c  = ch_r ? rdata_rt : rdata_l;

  smd_line #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_line_l (
    .clk(clk), .we(we_l), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_l)
  );
  smd_line #(.DEPTH(DELAY_DEPTH), .AW(AW)) u_line_rt (
    .clk(clk), .we(we_rt), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_rt)
  );

  // shared serial multiplier and its operand select
  logic                      mul_state, mul_start;
  logic signed [MUL_AW-1:0]  mul_a;
  logic        [MUL_BW-1:0]  mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_OFS: begin
        mul_a = MUL_AW'(sine_r);
        mul_b = MUL_BW'(md_r);
      end
      S_INTERP: begin
        mul_a = MUL_AW'(b_r) - MUL_AW'(a_r);
        mul_b = MUL_BW'(f_r);
      end
      S_LP: begin
        mul_a = MUL_AW'(rd_r) - MUL_AW'(lp_cur);
        mul_b = MUL_BW'(coeff_r);
      end
      S_FB: begin
        mul_a = MUL_AW'(lp_cur);
        mul_b = MUL_BW'(fb_r);
      end
      S_MIX1: begin
        mul_a = MUL_AW'(x_cur);
        mul_b = MIX_ONE - mix_eff;
      end
      S_MIX2: begin
        mul_a = MUL_AW'(lp_cur);
        mul_b = mix_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_state = (state_r == S_OFS) || (state_r == S_INTERP) || (state_r == S_LP) ||
                     (state_r == S_FB) || (state_r == S_MIX1) || (state_r == S_MIX2);
  assign mul_start = mul_state && !mul_pend_r;

  smd_sermul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  // handshakes
  logic in_acc, out_load;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_rt_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_addr_r == AW'(DELAY_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_acc) state_nxt = byp_r ? S_OUT : S_LFO;
      S_LFO:    state_nxt = S_OFS;
      S_OFS:    if (mul_done) state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_RDA;
      S_RDA:    state_nxt = S_RDB;
      S_RDB:    state_nxt = S_RDW;
      S_RDW:    state_nxt = S_INTERP;
      S_INTERP: if (mul_done) state_nxt = S_LP;
      S_LP:     if (mul_done) state_nxt = S_FB;
      S_FB:     if (mul_done) state_nxt = S_MIX1;
      S_MIX1:   if (mul_done) state_nxt = S_MIX2;
      S_MIX2:   if (mul_done) state_nxt = ch_r ? S_OUT : S_ADDR;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      mul_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ch_r        <= 1'b0;
      wp_r        <= '0;
      phase_r     <= '0;
      lpf_l_r     <= '0;
      lpf_rt_r    <= '0;
      base_r      <= BASE_DELAY_RST;
      md_r        <= MOD_DEPTH_RST;
      fb_r        <= FEEDBACK_RST;
      mix_r       <= WET_MIX_RST;
      coeff_r     <= LP_COEFF_RST;
      inc_r       <= LFO_INC_RST;
      byp_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_addr_r <= clr_addr_r + 1'b1;

      if (mul_start) mul_pend_r <= 1'b1;
      else if (mul_done) mul_pend_r <= 1'b0;

      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (in_acc) ch_r <= 1'b0;
      else if ((state_r == S_MIX2) && mul_done) ch_r <= !ch_r;

      // lowpass state follows the read value
      if ((state_r == S_LP) && mul_done) begin
        if (ch_r) lpf_rt_r <= sat24(48'(lp_cur) + 48'(prod_sh));
        else lpf_l_r <= sat24(48'(lp_cur) + 48'(prod_sh));
      end

      // end of frame: advance write position and lfo
      if ((state_r == S_MIX2) && mul_done && ch_r) begin
        wp_r    <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        phase_r <= phase_r + 32'(inc_r);
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DELAY: base_r  <= cfg_data[15:0];
          REG_MOD_DEPTH:  md_r    <= cfg_data[11:0];
          REG_FEEDBACK:   fb_r    <= cfg_data[15:0];
          REG_WET_MIX:    mix_r   <= cfg_data[16:0];
          REG_LP_COEFF:   coeff_r <= cfg_data[15:0];
          REG_LFO_INC:    inc_r   <= cfg_data[23:0];
          REG_BYPASS:     byp_r   <= cfg_data[0];
          default:        ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_l_r  <= in_left;
      x_rt_r <= in_right;
      y_l_r  <= in_left;
      y_rt_r <= in_right;
    end
    if (state_r == S_LFO) sine_r <= phase_r[31] ? -lfo_mag : lfo_mag;
    if ((state_r == S_OFS) && mul_done) off_r <= mul_p[MUL_PW-1:7];
    if (state_r == S_ADDR) begin
      n_r <= dly_c[AW+15:16];
      f_r <= dly_c[15:0];
    end
    if (state_r == S_RDB) a_r <= rdata_c;
    if (state_r == S_RDW) b_r <= rdata_c;
    if ((state_r == S_INTERP) && mul_done) rd_r <= 24'(28'(a_r) + 28'(prod_sh));
    if ((state_r == S_MIX1) && mul_done) acc_r <= mul_p;
    if ((state_r == S_MIX2) && mul_done) begin
      if (ch_r) y_rt_r <= sat24(48'((44'(acc_r) + 44'(mul_p)) >>> 16));
      else y_l_r <= sat24(48'((44'(acc_r) + 44'(mul_p)) >>> 16));
    end
    if (out_load) begin
      out_l_r  <= y_l_r;
      out_rt_r <= y_rt_r;
    end
  end

endmodule

[hdl/smd_sermul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
module smd_sermul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [smd_pkg::MUL_AW-1:0] a,
  input  logic        [smd_pkg::MUL_BW-1:0] b,
  output logic                              done,
  output logic signed [smd_pkg::MUL_PW-1:0] p
);
  import smd_pkg::*;

  localparam int CW = $clog2(MUL_BW + 1);

  logic signed [MUL_PW-1:0] a_r;
  logic        [MUL_BW-1:0] b_r;
  logic signed [MUL_PW-1:0] acc_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r;
  logic                     done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MUL_BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= MUL_PW'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r <<< 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[hdl/smd_line.sv]
// one delay line: single write port, registered read port
module smd_line #(
  parameter int DEPTH = smd_pkg::DELAY_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [23:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [23:0]   rdata
);
  logic signed [23:0] mem [0:DEPTH-1];
  logic signed [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/smd_check.sv]
// port-level checks of the modulated delay, bound to the top level
module smd_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [smd_pkg::SAMPLE_W-1:0] out_left,
  input logic signed [smd_pkg::SAMPLE_W-1:0] out_right
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output request dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left) && $stable(out_right))
    else $error("stalled output changed");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second frame taken while busy");

  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall) else $error("input open during reset or line clear");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");
endmodule

bind stereo_modulated_delay_core smd_check u_smd_check (.*);
